FILE: hdl/nvq_pkg.sv
// nvq_pkg: shared types, codes and helpers for the NVMe I/O queue engine.
// Used by nvq_front, nvq_fifo, nvq_back and nvme_io_queue_engine.
`default_nettype none

package nvq_pkg;

    localparam logic [63:0] PAGE_BYTES   = 64'h1000;
    localparam logic [63:0] BELL_BASE    = 64'h1000;
    localparam logic [31:0] NSID_IO      = 32'd1;
    localparam logic [7:0]  OPC_WRITE    = 8'h01;
    localparam logic [7:0]  OPC_READ     = 8'h02;
    localparam int          SQ_DWORDS    = 16;
    localparam int          PRP_CNT_W    = 5;   // up to 30 list dwords for a 7-bit count
    localparam int          FIFO_DEPTH   = 2;

    localparam logic [1:0] CFG_BOUNCE    = 2'd0;
    localparam logic [1:0] CFG_PRP_LIST  = 2'd1;
    localparam logic [1:0] CFG_IO_SQ     = 2'd2;
    localparam logic [1:0] CFG_STRIDE    = 2'd3;

    localparam logic [1:0] BELL_SQ_TAIL  = 2'd2;

    typedef enum logic [2:0] {
        KIND_SQ   = 3'd0,
        KIND_PRP  = 3'd1,
        KIND_BELL = 3'd2,
        KIND_DONE = 3'd3,
        KIND_PEND = 3'd4,
        KIND_REJ  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        OP_ISSUE,
        OP_CPL,
        OP_PEND,
        OP_REJ
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRP,
        ST_SQ,
        ST_BELL,
        ST_FINAL
    } state_t;

    // Work descriptor handed from the front end to the sequencer.
    typedef struct packed {
        op_t                  op;
        logic [31:0]          cmd0;
        logic [63:0]          prp2;
        logic [63:0]          lba;
        logic [15:0]          nlb;
        logic [PRP_CNT_W-1:0] prp_dw;
        logic [63:0]          sq_addr;
        logic [1:0]           bell_n;
        logic [31:0]          bell_val;
        logic [14:0]          status;
    } desc_t;

    // Submission entry dword by index.
    function automatic logic [31:0] sq_word(input logic [3:0] idx, input desc_t d,
                                            input logic [63:0] prp1);
        logic [31:0] w;
        w = '0;
        case (idx)
            4'd0:    w = d.cmd0;
            4'd1:    w = NSID_IO;
            4'd6:    w = prp1[31:0];
            4'd7:    w = prp1[63:32];
            4'd8:    w = d.prp2[31:0];
            4'd9:    w = d.prp2[63:32];
            4'd10:   w = d.lba[31:0];
            4'd11:   w = d.lba[63:32];
            4'd12:   w = {16'd0, d.nlb};
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/nvme_io_queue_engine.sv
// nvme_io_queue_engine: host side of one NVMe I/O queue pair.
// Input channel s_*: an issue item (s_action = 0) builds one read or write
// command over the bounce buffer; a completion item (s_action = 1) presents
// dword 3 of the completion entry at the head of queue s_queue_id.
// Result channel m_*: one beat per memory write or doorbell, then a status beat
// for completions; m_last marks the final beat of each item.
// Issue: 2*(pages-1) PRP list beats when more than two pages are used, 16
// submission beats and the tail doorbell: 17 to 31 beats, one per cycle while
// m_ready is high. Completion: doorbell and done beats on a phase match, else
// one pending beat. Rejected issues give one beat. The sequencer takes each
// descriptor in its idle state, which emits no beat; an accepted item reaches
// the output via the queue, the sequencer registers and the output register.
// A two-entry queue sits between front end and sequencer; s_ready drops only
// when it is full. A stalled m_ready holds the output register and the
// sequencer; the front end keeps taking items until the queue fills.
// Reset (aresetn low, synchronous) clears config registers, tail, heads,
// command id and sets both expected phases to one.
// Depends on nvq_pkg, nvq_front, nvq_fifo, nvq_back.
`default_nettype none

module nvme_io_queue_engine import nvq_pkg::*; #(
    parameter int QUEUE_DEPTH = 8,
    parameter int MAX_SECTORS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic        s_queue_id,
    input  wire logic        s_is_write,
    input  wire logic [63:0] s_start_lba,
    input  wire logic [6:0]  s_sector_count,
    input  wire logic [31:0] s_completion_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_kind,
    output logic [63:0]      m_address,
    output logic [31:0]      m_data,
    output logic [14:0]      m_status,
    output logic             m_failed,
    output logic             m_last
);

    logic [63:0] bounce_base_reg;
    logic [63:0] prp_list_base_reg;
    logic [63:0] io_sq_base_reg;
    logic [3:0]  stride_exp_reg;

    logic  accept;
    logic  fifo_full;
    logic  fifo_empty;
    logic  pop;
    desc_t push_desc;
    desc_t pop_desc;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounce_base_reg   <= '0;
            prp_list_base_reg <= '0;
            io_sq_base_reg    <= '0;
            stride_exp_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BOUNCE:   bounce_base_reg   <= cfg_wdata;
                CFG_PRP_LIST: prp_list_base_reg <= cfg_wdata;
                CFG_IO_SQ:    io_sq_base_reg    <= cfg_wdata;
                CFG_STRIDE:   stride_exp_reg    <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    nvq_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_SECTORS(MAX_SECTORS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .action         (s_action),
        .queue_id       (s_queue_id),
        .is_write       (s_is_write),
        .start_lba      (s_start_lba),
        .sector_count   (s_sector_count),
        .completion_word(s_completion_word),
        .bounce_base    (bounce_base_reg),
        .prp_list_base  (prp_list_base_reg),
        .io_sq_base     (io_sq_base_reg),
        .desc           (push_desc)
    );

    nvq_fifo u_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (accept),
        .din    (push_desc),
        .pop    (pop),
        .dout   (pop_desc),
        .full   (fifo_full),
        .empty  (fifo_empty)
    );

    nvq_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fifo_empty   (fifo_empty),
        .fifo_desc    (pop_desc),
        .pop          (pop),
        .bounce_base  (bounce_base_reg),
        .prp_list_base(prp_list_base_reg),
        .stride_exp   (stride_exp_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_address    (m_address),
        .m_data       (m_data),
        .m_status     (m_status),
        .m_failed     (m_failed),
        .m_last       (m_last)
    );

    // An accepted item always leaves something for the sequencer next cycle.
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !fifo_empty)
        else $error("accepted item not queued");

    // Status beats close their run.
    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_DONE || m_kind == KIND_PEND || m_kind == KIND_REJ)
        |-> m_last)
        else $error("status beat without last");

    // Failure is flagged only on done or rejected beats.
    a_failed_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_failed |-> (m_kind == KIND_DONE || m_kind == KIND_REJ))
        else $error("failed set on a write beat");

    // Pop only when the queue holds a descriptor.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: hdl/nvq_front.sv
// nvq_front: accepts items, checks them, owns queue state (tail, heads, phases,
// command id) and builds one work descriptor per item. Depends on nvq_pkg.
`default_nettype none

module nvq_front import nvq_pkg::*; #(
    parameter int QUEUE_DEPTH = 8,
    parameter int MAX_SECTORS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic        action,
    input  wire logic        queue_id,
    input  wire logic        is_write,
    input  wire logic [63:0] start_lba,
    input  wire logic [6:0]  sector_count,
    input  wire logic [31:0] completion_word,
    input  wire logic [63:0] bounce_base,
    input  wire logic [63:0] prp_list_base,
    input  wire logic [63:0] io_sq_base,
    output desc_t            desc
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);

    logic [QW-1:0] tail_reg, tail_next;
    logic [QW-1:0] head_reg [2];
    logic [QW-1:0] head_next [2];
    logic [1:0]    phase_reg, phase_next;
    logic [15:0]   cid_reg, cid_next;

    logic          reject;
    logic [7:0]    count_rnd;
    logic [4:0]    npages;
    logic [4:0]    npages_m1;
    logic [QW-1:0] tail_inc;
    logic [QW-1:0] head_inc;
    logic          phase_match;

    assign reject    = (sector_count == 7'd0) ||
                       ({25'd0, sector_count} > 32'(MAX_SECTORS));
    assign count_rnd = {1'b0, sector_count} + 8'd7;
    assign npages    = count_rnd[7:3];
    assign npages_m1 = npages - 5'd1;
    assign tail_inc  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + QW'(1);
    assign head_inc  = (head_reg[queue_id] == LAST_SLOT) ? '0 : head_reg[queue_id] + QW'(1);
    assign phase_match = (completion_word[16] == phase_reg[queue_id]);

    always_comb begin
        tail_next    = tail_reg;
        head_next[0] = head_reg[0];
        head_next[1] = head_reg[1];
        phase_next   = phase_reg;
        cid_next     = cid_reg;

        desc          = '0;
        desc.op       = OP_REJ;
        desc.cmd0     = {cid_reg + 16'd1, 8'd0, is_write ? OPC_WRITE : OPC_READ};
        desc.lba      = start_lba;
        desc.nlb      = {9'd0, sector_count - 7'd1};
        desc.sq_addr  = io_sq_base + (64'(tail_reg) << 6);
        desc.status   = completion_word[31:17];

        if (action) begin
            desc.bell_n   = {queue_id, 1'b1};
            desc.bell_val = 32'(head_inc);
            if (phase_match) begin
                desc.op = OP_CPL;
            end else begin
                desc.op = OP_PEND;
            end
        end else begin
            desc.bell_n   = BELL_SQ_TAIL;
            desc.bell_val = 32'(tail_inc);
            if (!reject) begin
                desc.op = OP_ISSUE;
            end
            if (npages == 5'd2) begin
                desc.prp2 = bounce_base + PAGE_BYTES;
            end else if (npages > 5'd2) begin
                desc.prp2   = prp_list_base;
                desc.prp_dw = {npages_m1[3:0], 1'b0};
            end
        end

        if (accept) begin
            case (desc.op)
                OP_ISSUE: begin
                    tail_next = tail_inc;
                    cid_next  = cid_reg + 16'd1;
                end
                OP_CPL: begin
                    head_next[queue_id] = head_inc;
                    if (head_inc == '0) begin
                        phase_next[queue_id] = ~phase_reg[queue_id];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_reg    <= '0;
            head_reg[0] <= '0;
            head_reg[1] <= '0;
            phase_reg   <= 2'b11;
            cid_reg     <= '0;
        end else begin
            tail_reg    <= tail_next;
            head_reg[0] <= head_next[0];
            head_reg[1] <= head_next[1];
            phase_reg   <= phase_next;
            cid_reg     <= cid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/nvq_fifo.sv
// nvq_fifo: two-entry descriptor queue between the front end and the sequencer.
// Depends on nvq_pkg.
`default_nettype none

module nvq_fifo import nvq_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire desc_t din,
    input  wire logic  pop,
    output desc_t      dout,
    output logic       full,
    output logic       empty
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    desc_t         mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/nvq_back.sv
// nvq_back: sequencer that walks one descriptor and emits its beats through an
// output register. Depends on nvq_pkg.
`default_nettype none

module nvq_back import nvq_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        fifo_empty,
    input  wire desc_t       fifo_desc,
    output logic             pop,
    input  wire logic [63:0] bounce_base,
    input  wire logic [63:0] prp_list_base,
    input  wire logic [3:0]  stride_exp,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_kind,
    output logic [63:0]      m_address,
    output logic [31:0]      m_data,
    output logic [14:0]      m_status,
    output logic             m_failed,
    output logic             m_last
);

    state_t               state_reg, state_next;
    desc_t                desc_reg, desc_next;
    logic [PRP_CNT_W-1:0] idx_reg, idx_next;
    logic [63:0]          addr_reg, addr_next;
    logic [63:0]          page_reg, page_next;

    logic        m_valid_reg, m_valid_next;
    kind_t       m_kind_reg, kind_next;
    logic [63:0] m_address_reg, address_next;
    logic [31:0] m_data_reg, data_next;
    logic [14:0] m_status_reg, status_next;
    logic        m_failed_reg, failed_next;
    logic        m_last_reg, last_next;

    logic        out_free;
    logic        emit;
    logic [63:0] bell_addr;

    assign out_free  = !m_valid_reg || m_ready;
    assign bell_addr = BELL_BASE + (64'({desc_reg.bell_n, 2'b00}) << stride_exp);

    always_comb begin
        state_next   = state_reg;
        desc_next    = desc_reg;
        idx_next     = idx_reg;
        addr_next    = addr_reg;
        page_next    = page_reg;
        pop          = 1'b0;
        emit         = 1'b0;
        kind_next    = KIND_DONE;
        address_next = '0;
        data_next    = '0;
        status_next  = '0;
        failed_next  = 1'b0;
        last_next    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (!fifo_empty) begin
                    pop       = 1'b1;
                    desc_next = fifo_desc;
                    idx_next  = '0;
                    page_next = bounce_base + PAGE_BYTES;
                    case (fifo_desc.op)
                        OP_ISSUE: begin
                            if (fifo_desc.prp_dw != '0) begin
                                state_next = ST_PRP;
                                addr_next  = prp_list_base;
                            end else begin
                                state_next = ST_SQ;
                                addr_next  = fifo_desc.sq_addr;
                            end
                        end
                        OP_CPL:  state_next = ST_BELL;
                        default: state_next = ST_FINAL;
                    endcase
                end
            end
            ST_PRP: begin
                kind_next    = KIND_PRP;
                address_next = addr_reg;
                data_next    = idx_reg[0] ? page_reg[63:32] : page_reg[31:0];
                if (out_free) begin
                    emit      = 1'b1;
                    addr_next = addr_reg + 64'd4;
                    if (idx_reg[0]) begin
                        page_next = page_reg + PAGE_BYTES;
                    end
                    if (idx_reg == desc_reg.prp_dw - PRP_CNT_W'(1)) begin
                        state_next = ST_SQ;
                        addr_next  = desc_reg.sq_addr;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + PRP_CNT_W'(1);
                    end
                end
            end
            ST_SQ: begin
                kind_next    = KIND_SQ;
                address_next = addr_reg;
                data_next    = sq_word(idx_reg[3:0], desc_reg, bounce_base);
                if (out_free) begin
                    emit      = 1'b1;
                    addr_next = addr_reg + 64'd4;
                    if (idx_reg == PRP_CNT_W'(SQ_DWORDS - 1)) begin
                        state_next = ST_BELL;
                    end else begin
                        idx_next = idx_reg + PRP_CNT_W'(1);
                    end
                end
            end
            ST_BELL: begin
                kind_next    = KIND_BELL;
                address_next = bell_addr;
                data_next    = desc_reg.bell_val;
                last_next    = (desc_reg.op == OP_ISSUE);
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = (desc_reg.op == OP_ISSUE) ? ST_IDLE : ST_FINAL;
                end
            end
            ST_FINAL: begin
                last_next = 1'b1;
                case (desc_reg.op)
                    OP_CPL: begin
                        kind_next   = KIND_DONE;
                        status_next = desc_reg.status;
                        failed_next = (desc_reg.status != '0);
                    end
                    OP_PEND: kind_next = KIND_PEND;
                    default: begin
                        kind_next   = KIND_REJ;
                        failed_next = 1'b1;
                    end
                endcase
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
        idx_reg  <= idx_next;
        addr_reg <= addr_next;
        page_reg <= page_next;
        if (emit) begin
            m_kind_reg    <= kind_next;
            m_address_reg <= address_next;
            m_data_reg    <= data_next;
            m_status_reg  <= status_next;
            m_failed_reg  <= failed_next;
            m_last_reg    <= last_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_address = m_address_reg;
    assign m_data    = m_data_reg;
    assign m_status  = m_status_reg;
    assign m_failed  = m_failed_reg;
    assign m_last    = m_last_reg;

endmodule

`default_nettype wire

FILE: verif/tb.sv
// tb: self-checking bench for nvme_io_queue_engine (issue and completion beats).
// Holds a queue-pair predictor, a valid/ready driver and monitor; depends on nvq_pkg.
`timescale 1ns / 100ps

module tb;
    import nvq_pkg::*;

    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_SECTORS = 64;
    localparam logic ACT_ISSUE = 1'b0;
    localparam logic ACT_CPL   = 1'b1;
    localparam logic [63:0] TOP_PAGE = 64'hFFFF_FFFF_FFFF_F000;

    typedef struct {
        logic        action;
        logic        queue_id;
        logic        is_write;
        logic [63:0] lba;
        logic [6:0]  count;
        logic [31:0] word;
    } item_t;

    typedef struct {
        kind_t       kind;
        logic [63:0] addr;
        logic [31:0] data;
        logic [14:0] status;
        logic        failed;
        logic        last;
    } beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_BOUNCE;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic        s_queue_id = 1'b0;
    logic        s_is_write = 1'b0;
    logic [63:0] s_start_lba = '0;
    logic [6:0]  s_sector_count = '0;
    logic [31:0] s_completion_word = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [63:0] m_address;
    logic [31:0] m_data;
    logic [14:0] m_status;
    logic        m_failed;
    logic        m_last;

    nvme_io_queue_engine #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_SECTORS(MAX_SECTORS)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_queue_id(s_queue_id), .s_is_write(s_is_write), .s_start_lba(s_start_lba),
        .s_sector_count(s_sector_count), .s_completion_word(s_completion_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_address(m_address),
        .m_data(m_data), .m_status(m_status), .m_failed(m_failed), .m_last(m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // register shadows and queue-pair state as the host sees it
    logic [63:0] reg_bounce = '0;
    logic [63:0] reg_prp_list = '0;
    logic [63:0] reg_io_sq = '0;
    logic [3:0]  reg_stride = '0;
    int unsigned sq_tail = 0;
    int unsigned cq_head [2] = '{0, 0};
    logic        head_phase [2] = '{1'b1, 1'b1};
    logic [15:0] cmd_id = '0;

    // generator-side phase tracking, used to build matching completions
    int unsigned gen_head [2] = '{0, 0};
    logic        gen_phase [2] = '{1'b1, 1'b1};

    item_t pending_items [$];
    beat_t bus_beats_due [$];
    item_t cur_item;
    beat_t want;

    int err_count = 0;
    int beats_checked = 0;
    int n_issue = 0, n_rej = 0, n_cpl = 0, n_pend = 0, n_cfg = 0;
    int src_gap = 0, sink_gap = 0, hold_left = 0;
    int hold_asks = 0, hold_seen = 0;
    bit idle_on = 1'b1;

    task automatic flag_error(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void queue_beat(input kind_t k, input logic [63:0] a,
                                       input logic [31:0] d, input logic [14:0] st,
                                       input logic f, input logic l);
        beat_t b;
        b.kind = k;
        b.addr = a;
        b.data = d;
        b.status = st;
        b.failed = f;
        b.last = l;
        bus_beats_due.push_back(b);
    endfunction

    // Expected write stream for one accepted item; advances the shadow state.
    function automatic void predict_bus_beats(input item_t it);
        int unsigned pages;
        int unsigned q;
        logic [63:0] stride, p2, pg, at, slot;
        logic [31:0] cmd [16];
        logic [14:0] st;
        stride = 64'd4 << reg_stride;
        if (it.action == ACT_CPL) begin
            q = it.queue_id;
            if (it.word[16] !== head_phase[q]) begin
                n_pend++;
                queue_beat(KIND_PEND, '0, '0, '0, 1'b0, 1'b1);
                return;
            end
            n_cpl++;
            st = it.word[31:17];
            cq_head[q] = (cq_head[q] + 1) % QUEUE_DEPTH;
            if (cq_head[q] == 0)
                head_phase[q] = ~head_phase[q];
            queue_beat(KIND_BELL, BELL_BASE + 64'(2 * q + 1) * stride, 32'(cq_head[q]),
                       '0, 1'b0, 1'b0);
            queue_beat(KIND_DONE, '0, '0, st, st != 15'd0, 1'b1);
            return;
        end
        if (it.count == 7'd0 || it.count > MAX_SECTORS) begin
            n_rej++;
            queue_beat(KIND_REJ, '0, '0, '0, 1'b1, 1'b1);
            return;
        end
        n_issue++;
        pages = (int'(it.count) * 512 + 4095) / 4096;
        p2 = '0;
        if (pages == 2) begin
            p2 = reg_bounce + PAGE_BYTES;
        end else if (pages > 2) begin
            for (int i = 0; i + 1 < pages; i++) begin
                pg = reg_bounce + 64'(i + 1) * PAGE_BYTES;
                at = reg_prp_list + 64'(i) * 64'd8;
                queue_beat(KIND_PRP, at, pg[31:0], '0, 1'b0, 1'b0);
                queue_beat(KIND_PRP, at + 64'd4, pg[63:32], '0, 1'b0, 1'b0);
            end
            p2 = reg_prp_list;
        end
        cmd_id = cmd_id + 16'd1;
        foreach (cmd[i]) cmd[i] = '0;
        cmd[0] = {cmd_id, 8'h00, it.is_write ? OPC_WRITE : OPC_READ};
        cmd[1] = NSID_IO;
        cmd[6] = reg_bounce[31:0];
        cmd[7] = reg_bounce[63:32];
        cmd[8] = p2[31:0];
        cmd[9] = p2[63:32];
        cmd[10] = it.lba[31:0];
        cmd[11] = it.lba[63:32];
        cmd[12] = {16'd0, 16'(it.count - 7'd1)};
        slot = reg_io_sq + 64'(sq_tail) * 64'd64;
        for (int i = 0; i < SQ_DWORDS; i++)
            queue_beat(KIND_SQ, slot + 64'(i) * 64'd4, cmd[i], '0, 1'b0, 1'b0);
        sq_tail = (sq_tail + 1) % QUEUE_DEPTH;
        queue_beat(KIND_BELL, BELL_BASE + 64'(BELL_SQ_TAIL) * stride, 32'(sq_tail),
                   '0, 1'b0, 1'b1);
    endfunction

    task automatic add_issue(input logic w, input logic [63:0] lba, input logic [6:0] cnt);
        item_t it;
        it.action = ACT_ISSUE;
        it.queue_id = 1'($urandom);
        it.is_write = w;
        it.lba = lba;
        it.count = cnt;
        it.word = $urandom;
        pending_items.push_back(it);
    endtask

    task automatic add_completion(input int unsigned q, input logic [14:0] st,
                                  input bit match);
        item_t it;
        it.action = ACT_CPL;
        it.queue_id = q[0];
        it.is_write = 1'($urandom);
        it.lba = {$urandom, $urandom};
        it.count = 7'($urandom);
        it.word = {st, match ? gen_phase[q] : ~gen_phase[q], 16'($urandom)};
        if (match) begin
            gen_head[q] = (gen_head[q] + 1) % QUEUE_DEPTH;
            if (gen_head[q] == 0)
                gen_phase[q] = ~gen_phase[q];
        end
        pending_items.push_back(it);
    endtask

    task automatic gen_random_items(input int n);
        logic [6:0]  cnt;
        logic [14:0] st;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 55) begin
                if ($urandom_range(0, 9) == 0)
                    cnt = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
                else
                    cnt = 7'($urandom_range(1, MAX_SECTORS));
                add_issue(1'($urandom), {$urandom, $urandom}, cnt);
            end else begin
                st = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'd0;
                add_completion($urandom_range(0, 1), st, $urandom_range(0, 6) != 0);
            end
        end
    endtask

    // one register per cycle, only while the engine is idle
    task automatic write_regs(input logic [63:0] bounce, input logic [63:0] prp,
                              input logic [63:0] sq, input logic [3:0] stride);
        logic [63:0] vals [4];
        logic [1:0]  idx [4];
        vals = '{bounce, prp, sq, {60'($urandom), stride}};
        idx = '{CFG_BOUNCE, CFG_PRP_LIST, CFG_IO_SQ, CFG_STRIDE};
        for (int i = 0; i < 4; i++) begin
            @(posedge aclk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        reg_bounce = bounce;
        reg_prp_list = prp;
        reg_io_sq = sq;
        reg_stride = stride;
        n_cfg++;
    endtask

    function automatic logic [63:0] rand_page();
        return {$urandom, $urandom} & ~64'hFFF;
    endfunction

    task automatic wait_drained();
        int k;
        k = 0;
        while ((pending_items.size() != 0 || s_valid || bus_beats_due.size() != 0)
               && k < 200000) begin
            @(negedge aclk);
            k++;
        end
        repeat (8) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_bus_beats(cur_item);
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_action <= cur_item.action;
                    s_queue_id <= cur_item.queue_id;
                    s_is_write <= cur_item.is_write;
                    s_start_lba <= cur_item.lba;
                    s_sector_count <= cur_item.count;
                    s_completion_word <= cur_item.word;
                    if (idle_on && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 18);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side flow control
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_checked++;
                if (bus_beats_due.size() == 0) begin
                    flag_error($sformatf("unexpected beat kind %0d addr %h data %h",
                                         m_kind, m_address, m_data));
                end else begin
                    want = bus_beats_due.pop_front();
                    if (m_kind !== want.kind)
                        flag_error($sformatf("beat %0d kind %0d, want %0d",
                                             beats_checked, m_kind, want.kind));
                    if (m_address !== want.addr)
                        flag_error($sformatf("beat %0d address %h, want %h",
                                             beats_checked, m_address, want.addr));
                    if (m_data !== want.data)
                        flag_error($sformatf("beat %0d data %h, want %h",
                                             beats_checked, m_data, want.data));
                    if (m_status !== want.status)
                        flag_error($sformatf("beat %0d status %h, want %h",
                                             beats_checked, m_status, want.status));
                    if (m_failed !== want.failed)
                        flag_error($sformatf("beat %0d failed %b, want %b",
                                             beats_checked, m_failed, want.failed));
                    if (m_last !== want.last)
                        flag_error($sformatf("beat %0d last %b, want %b",
                                             beats_checked, m_last, want.last));
                end
            end
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 17);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero bases, smallest stride
        write_regs('0, '0, '0, 4'd0);
        add_issue(1'b0, 64'd0, 7'd1);
        add_issue(1'b1, '1, 7'd8);
        add_issue(1'b0, 64'h0123_4567_89AB_CDEF, 7'd9);
        add_issue(1'b1, 64'hFEDC_BA98_7654_3210, 7'd16);
        add_issue(1'b0, 64'h8000_0000_0000_0001, 7'd17);
        add_issue(1'b1, 64'h5555_AAAA_5555_AAAA, 7'd64);
        add_issue(1'b1, 64'd0, 7'd0);              // zero count
        add_issue(1'b0, '1, 7'd65);                // just above the limit
        add_issue(1'b1, 64'd7, 7'd127);
        add_completion(1, 15'd0, 1'b1);
        add_completion(1, 15'd0, 1'b0);            // stale phase
        add_completion(0, 15'h7FFF, 1'b1);         // error status still advances head
        add_completion(0, 15'd1, 1'b1);
        repeat (6) add_completion(0, 15'd0, 1'b1); // head wraps, phase flips
        add_completion(0, 15'h2AAA, 1'b1);
        add_completion(0, 15'd0, 1'b0);
        add_issue(1'b0, 64'hAAAA_5555_AAAA_5555, 7'd64);
        wait_drained();

        // random bases; receiver holds off long enough to back up the input
        write_regs(rand_page(), rand_page(), rand_page(), 4'($urandom_range(1, 14)));
        gen_random_items(35);
        hold_asks++;
        wait_drained();

        // top-of-memory bases (sums wrap) and widest stride
        write_regs(TOP_PAGE, TOP_PAGE, TOP_PAGE, 4'd15);
        add_issue(1'b1, '1, 7'd64);
        add_issue(1'b0, 64'd0, 7'd17);
        gen_random_items(35);
        wait_drained();

        // last stretch at full rate
        idle_on = 1'b0;
        write_regs(rand_page(), rand_page(), rand_page(), 4'($urandom_range(0, 15)));
        gen_random_items(35);
        wait_drained();
        repeat (20) @(posedge aclk);

        if (bus_beats_due.size() != 0)
            flag_error($sformatf("%0d expected beats never arrived", bus_beats_due.size()));
        $display("covered %0d issues, %0d rejects, %0d completions, %0d pending checks",
                 n_issue, n_rej, n_cpl, n_pend);
        $display("%0d beats checked over %0d register settings, %0d mismatches",
                 beats_checked, n_cfg, err_count);
        if (err_count == 0) begin
            $display("nvme_io_queue_engine regression: pass");
        end else begin
            $display("nvme_io_queue_engine regression: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout waiting on the engine");
        $display("nvme_io_queue_engine regression: fail");
        $finish;
    end

endmodule
